// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL file that checks itself.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk_i, quiet while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/atp_pkg.sv =====
// ---------------------------------------------------------------------------
// atp_pkg
// Constants, register codes and stage payload types of the tone period block.
// ---------------------------------------------------------------------------
package atp_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int CLOCK_LOG2  = 20;
  localparam int FRAC_BITS   = 4;

  localparam int SAMPLE_W   = 10;
  localparam int GAIN_W     = 8;
  localparam int OFFSET_W   = 16;
  localparam int PERIOD_W   = 16;
  localparam int HALF_W     = 15;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 8'd24;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd1010;

  // Sample bits that take part in the product.
  localparam int SAMPLE_USED = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int NUM_LOG2    = CLOCK_LOG2 + FRAC_BITS;
  localparam int PROD_W      = GAIN_W + SAMPLE_USED;
  localparam int OFFS_W      = OFFSET_W + FRAC_BITS;
  localparam int DEN_W       = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 1;
  localparam int REM_W       = DEN_W + 1;

  // The quotient overflows PERIOD_W bits exactly when den <= 2^SAT_LOG2.
  localparam int SAT_LOG2 = NUM_LOG2 - PERIOD_W;
  localparam logic [DEN_W-1:0] SAT_DEN  = DEN_W'(1) << SAT_LOG2;
  localparam logic [REM_W-1:0] REM_INIT = REM_W'(1) << SAT_LOG2;

  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = PERIOD_W / BITS_PER_STAGE;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_Q4 = 8'd0,
    REG_OFFSET  = 8'd1
  } atp_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_q4;
    logic [OFFSET_W-1:0] offset;
  } atp_cfg_t;

  typedef struct packed {
    logic                sat;
    logic [DEN_W-1:0]    den;
    logic [REM_W-1:0]    rem;
    logic [PERIOD_W-1:0] quo;
  } atp_div_t;

endpackage

// ===== rtl/atp_if.sv =====
// ---------------------------------------------------------------------------
// atp channel interfaces
// Valid/ready channels for samples, results and register writes.
// ---------------------------------------------------------------------------
interface atp_sample_if;
  logic                          valid;
  logic                          ready;
  logic [atp_pkg::SAMPLE_W-1:0]  adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface atp_result_if;
  logic                          valid;
  logic                          ready;
  logic [atp_pkg::PERIOD_W-1:0]  period;
  logic [atp_pkg::HALF_W-1:0]    half_period;
  logic                          saturated;

  modport source (output valid, output period, output half_period, output saturated,
                  input ready);
  modport sink (input valid, input period, input half_period, input saturated,
                output ready);
endinterface

interface atp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [atp_pkg::CFG_IDX_W-1:0]  index;
  logic [atp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/adc_to_tone_period.sv =====
// ---------------------------------------------------------------------------
// adc_to_tone_period
// Converter sample to tone timer period and half-period compare values.
// ---------------------------------------------------------------------------
// Each sample beat yields one result beat: period = floor(2^24 /
// (gain_q4 * sample + 16 * offset)), clipped to 65535 with saturated set
// when the quotient is too large or the denominator is zero, and
// half_period = period >> 1. The block takes one sample, and its division
// pipeline one denominator, per cycle while the result side does not
// stall. One stage multiplies and adds, four restoring-division stages
// produce four quotient bits each, and an output register holds the
// result. Each stage has its own valid bit and moves whenever the stage
// after it is free, so bubbles close up while a result waits at the
// output. Registers (index 0 gain_q4, index 1 offset) reset to 24 and
// 1010; they must be written only while the block is idle, which the
// block itself does not enforce, and writes to other indexes are dropped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_to_tone_period (
  input  logic         clk_i,
  input  logic         rst_ni,
  atp_sample_if.sink   sample_i,
  atp_result_if.source result_o,
  atp_cfg_if.sink      cfg_i
);

  localparam int LAST = atp_pkg::DIV_STAGES;

  atp_pkg::atp_cfg_t cfg;

  // Stage 0 is the denominator stage; stages 1..LAST are division stages.
  logic [LAST:0]      st_valid;
  logic [LAST:0]      st_ready;
  atp_pkg::atp_div_t  st_data [LAST+1];

  logic                          res_valid_q;
  logic [atp_pkg::PERIOD_W-1:0]  period_d, period_q;
  logic                          sat_q;

  // Register file.
  atp_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Multiply, add offset and decide saturation up front.
  atp_den u_den (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sample_i.valid),
    .ready_o  (sample_i.ready),
    .sample_i (sample_i.adc_sample),
    .cfg_i    (cfg),
    .valid_o  (st_valid[0]),
    .ready_i  (st_ready[0]),
    .data_o   (st_data[0])
  );

  // Division pipeline, one stage per group of quotient bits.
  for (genvar s = 0; s < LAST; s++) begin : g_div
    atp_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[s]),
      .ready_o (st_ready[s]),
      .data_i  (st_data[s]),
      .valid_o (st_valid[s+1]),
      .ready_i (st_ready[s+1]),
      .data_o  (st_data[s+1])
    );
  end

  // Output register: take the last stage whenever it is empty or drained.
  assign st_ready[LAST] = !res_valid_q || result_o.ready;

  // Clip to full scale on overflow or a zero denominator.
  assign period_d = st_data[LAST].sat ? '1 : st_data[LAST].quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (st_ready[LAST]) begin
      res_valid_q <= st_valid[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_valid[LAST] && st_ready[LAST]) begin
      period_q <= period_d;
      sat_q    <= st_data[LAST].sat;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.period      = period_q;
  assign result_o.half_period = period_q[atp_pkg::PERIOD_W-1:1];
  assign result_o.saturated   = sat_q;

  // An accepted sample shows up in the denominator stage next cycle.
  `ASSERT_CLK(a_accept_enters, sample_i.valid && sample_i.ready |=> st_valid[0], "sample beat lost at pipeline entry")

  // A blocked final stage keeps its item.
  `ASSERT_CLK(a_last_holds, st_valid[LAST] && !st_ready[LAST] |=> st_valid[LAST] && $stable(st_data[LAST].quo), "final division stage dropped a stalled item")

  // Without overflow the remainder stays below the divisor.
  `ASSERT_CLK(a_rem_bound, st_valid[LAST] && !st_data[LAST].sat |-> st_data[LAST].rem < {1'b0, st_data[LAST].den}, "division remainder out of range")

endmodule

// ===== rtl/atp_cfg.sv =====
// ---------------------------------------------------------------------------
// atp_cfg
// Gain and offset registers behind the write channel.
// ---------------------------------------------------------------------------
module atp_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  atp_cfg_if.sink            cfg_i,
  output atp_pkg::atp_cfg_t  cfg_o
);

  atp_pkg::atp_cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      // Drop writes to unknown indexes.
      if (cfg_i.index == atp_pkg::REG_GAIN_Q4) begin
        cfg_d.gain_q4 = cfg_i.data[atp_pkg::GAIN_W-1:0];
      end else if (cfg_i.index == atp_pkg::REG_OFFSET) begin
        cfg_d.offset = cfg_i.data[atp_pkg::OFFSET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_q4 <= atp_pkg::GAIN_RESET;
      cfg_q.offset  <= atp_pkg::OFFSET_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/atp_den.sv =====
// ---------------------------------------------------------------------------
// atp_den
// First stage: form the Q.4 denominator and flag quotient overflow.
// ---------------------------------------------------------------------------
module atp_den (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [atp_pkg::SAMPLE_W-1:0]  sample_i,
  input  atp_pkg::atp_cfg_t             cfg_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output atp_pkg::atp_div_t             data_o
);

  logic                           valid_q;
  atp_pkg::atp_div_t              data_d, data_q;
  logic [atp_pkg::PROD_W-1:0]     prod;
  logic [atp_pkg::DEN_W-1:0]      den;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    prod = cfg_i.gain_q4 * sample_i[atp_pkg::SAMPLE_USED-1:0];
    den  = atp_pkg::DEN_W'(prod)
         + atp_pkg::DEN_W'({cfg_i.offset, {atp_pkg::FRAC_BITS{1'b0}}});
    data_d.den = den;
    data_d.sat = (den <= atp_pkg::SAT_DEN);
    data_d.rem = atp_pkg::REM_INIT;
    data_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/atp_div_stage.sv =====
// ---------------------------------------------------------------------------
// atp_div_stage
// One restoring division stage: four quotient bits per register stage.
// ---------------------------------------------------------------------------
module atp_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  atp_pkg::atp_div_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output atp_pkg::atp_div_t  data_o
);

  logic               valid_q;
  atp_pkg::atp_div_t  data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // The numerator bits below the initial remainder are all zero, so only
  // zeros shift in.
  always_comb begin
    logic [atp_pkg::REM_W-1:0] r2;
    data_d = data_i;
    for (int i = 0; i < atp_pkg::BITS_PER_STAGE; i++) begin
      r2 = {data_d.rem[atp_pkg::REM_W-2:0], 1'b0};
      data_d.quo = {data_d.quo[atp_pkg::PERIOD_W-2:0], 1'b0};
      if (r2 >= {1'b0, data_d.den}) begin
        data_d.rem    = r2 - {1'b0, data_d.den};
        data_d.quo[0] = 1'b1;
      end else begin
        data_d.rem = r2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== sim/atp_period_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// atp_period_checker
// Watches the sample, result and register channels of the tone period block,
// predicts each result from its own copy of the registers and compares.
// ---------------------------------------------------------------------------
module atp_period_checker
  import atp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  atp_sample_if sample_i,
  atp_result_if result_i,
  atp_cfg_if    cfg_i,
  output int    fail_count_o,
  output int    pending_o
);

  localparam logic [63:0] PERIOD_MAX = (64'd1 << PERIOD_W) - 64'd1;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [HALF_W-1:0]   half_period;
    logic                saturated;
  } tone_res_t;

  logic [GAIN_W-1:0]   gain_q4;
  logic [OFFSET_W-1:0] offset;
  tone_res_t           tone_q[$];
  tone_res_t           want;
  int                  fails;

  function automatic tone_res_t tone_expect(input logic [GAIN_W-1:0]   g,
                                            input logic [OFFSET_W-1:0] o,
                                            input logic [SAMPLE_W-1:0] s);
    logic [63:0] smp;
    logic [63:0] den;
    logic [63:0] quo;
    tone_res_t   r;
    smp = 64'(s) & ((64'd1 << SAMPLE_BITS) - 64'd1);
    den = 64'(g) * smp + (64'(o) << FRAC_BITS);
    r.saturated = 1'b0;
    if (den == 64'd0) begin
      quo = PERIOD_MAX;
      r.saturated = 1'b1;
    end else begin
      quo = (64'd1 << NUM_LOG2) / den;
      if (quo > PERIOD_MAX) begin
        quo = PERIOD_MAX;
        r.saturated = 1'b1;
      end
    end
    r.period      = quo[PERIOD_W-1:0];
    r.half_period = quo[PERIOD_W-1:1];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q4 = GAIN_RESET;
      offset  = OFFSET_RESET;
      tone_q.delete();
      fails = 0;
    end else begin
      // Registers must change only while idle; the block does not enforce it.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_GAIN_Q4: gain_q4 = cfg_i.data[GAIN_W-1:0];
          REG_OFFSET:  offset  = cfg_i.data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (sample_i.valid && sample_i.ready)
        tone_q.push_back(tone_expect(gain_q4, offset, sample_i.adc_sample));
      if (result_i.valid && result_i.ready) begin
        if (tone_q.size() == 0) begin
          $error("result beat with nothing expected: period %0d", result_i.period);
          fails++;
        end else begin
          want = tone_q.pop_front();
          if (result_i.period !== want.period) begin
            $error("period: expected %0d, got %0d", want.period, result_i.period);
            fails++;
          end
          if (result_i.half_period !== want.half_period) begin
            $error("half_period: expected %0d, got %0d", want.half_period,
                   result_i.half_period);
            fails++;
          end
          if (result_i.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated,
                   result_i.saturated);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= tone_q.size();
  end

endmodule

// ===== sim/tb_adc_to_tone_period.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_adc_to_tone_period
// Stimulus and verdict for the tone period block: directed corner samples,
// then phases of random samples under changing gain and offset settings,
// with random gaps on the sample side and random stalls on the result side.
// ---------------------------------------------------------------------------
module tb_adc_to_tone_period;
  import atp_pkg::*;

  localparam int DUT_LATENCY    = 6;
  localparam int SETTLE_CYCLES  = 2 * DUT_LATENCY;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 150;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int FIRST_UNUSED_IDX = int'(REG_OFFSET) + 1;
  localparam int IDX_MAX        = (1 << CFG_IDX_W) - 1;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   steady;  // when set, the sample side sends back to back

  atp_sample_if smp_if ();
  atp_result_if res_if ();
  atp_cfg_if    cfg_if ();

  adc_to_tone_period dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  atp_period_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (smp_if),
    .result_i     (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Drive one sample beat. Valid stays high on return so that a following
  // beat with no gap follows on without valid dropping in between.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      smp_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp_if.valid      = 1'b1;
    smp_if.adc_sample = s;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back, then
  // wait out the settle time so the pipeline is empty.
  task automatic drain();
    smp_if.valid = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register beat; valid is left high for a following beat.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Load both registers while idle. Random upper bits on the gain word check
  // masking, and a write to an unused index now and then must be dropped.
  task automatic load_regs(input logic [GAIN_W-1:0] gain, input logic [OFFSET_W-1:0] offs);
    drain();
    write_reg(REG_GAIN_Q4, {8'($urandom), gain});
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, IDX_MAX)),
                CFG_DATA_W'($urandom));
    write_reg(REG_OFFSET, offs);
    cfg_if.valid = 1'b0;
  endtask

  // Random sample, biased toward the ends of the range and the region where
  // a gain_q4 of 1 with no offset crosses into saturation.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      6:       return '0;
      7:       return SAMPLE_W'(SAMPLE_MAX);
      8:       return SAMPLE_W'($urandom_range(0, 15));
      9:       return SAMPLE_W'($urandom_range(240, 272));
      default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  // Result side: long stall-free stretches now and then, short runs of ready
  // broken by random stalls otherwise.
  initial begin
    int run;
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      res_if.ready = 1'b1;
      repeat (run) @(negedge clk_i);
      gap = gap_len();
      if (gap > 0) begin
        res_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[adc_to_tone_period] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [GAIN_W-1:0]   gain;
    logic [OFFSET_W-1:0] offs;
    smp_if.valid      = 1'b0;
    smp_if.adc_sample = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    steady            = 1'b0;
    rst_ni            = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: range ends and alternating bit patterns.
    send_sample('0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(512));
    send_sample(SAMPLE_W'(10'h2AA));
    send_sample(SAMPLE_W'(10'h155));

    // No gain and no offset: the denominator is zero for every sample.
    load_regs(8'd0, 16'd0);
    send_sample('0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));

    // Gain code 1, no offset: the quotient clips up to a denominator of 256.
    load_regs(8'd1, 16'd0);
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(256));
    send_sample(SAMPLE_W'(257));
    send_sample(SAMPLE_W'(SAMPLE_MAX));

    // Offset alone sits right on the clipping edge at sample zero.
    load_regs(8'd16, 16'd16);
    send_sample('0);
    send_sample(SAMPLE_W'(1));

    // Largest denominator: shortest period.
    load_regs(8'hFF, 16'hFFFF);
    send_sample('0);
    send_sample(SAMPLE_W'(SAMPLE_MAX));

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph == 0 ? 6 : ph == 1 ? 7 : $urandom_range(0, 5))
        0: begin
          gain = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          offs = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        1: begin
          gain = GAIN_RESET;
          offs = OFFSET_RESET;
        end
        2: begin
          gain = GAIN_W'($urandom);
          offs = OFFSET_W'($urandom_range(0, 32));
        end
        3: begin
          gain = GAIN_W'($urandom);
          offs = OFFSET_W'($urandom);
        end
        4: begin
          gain = '0;
          offs = OFFSET_W'($urandom_range(0, 16));
        end
        5: begin
          gain = GAIN_W'($urandom);
          offs = OFFSET_W'($urandom_range(0, 1023));
        end
        6: begin
          gain = 8'hFF;
          offs = 16'h0000;
        end
        default: begin
          gain = 8'h01;
          offs = 16'hFFFF;
        end
      endcase
      load_regs(gain, offs);
      steady = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_sample(rand_sample());
    end

    // Let the last results out and give the verdict.
    drain();
    if (fail_count == 0) begin
      $display("[adc_to_tone_period] OK");
    end else begin
      $display("[adc_to_tone_period] ERROR");
    end
    $finish;
  end

endmodule
